// ----- rtl/core/lcx_pkg.sv -----
// Shared types, codes and character helpers for the C subset lexer.
package lcx_pkg;

  localparam int IDENT_CHARS_KEPT = 8;

  localparam int NUM_W   = 63;
  localparam int TEXT_W  = 64;
  localparam int LEN_W   = 8;
  localparam int PUNCT_W = 5;
  localparam int KW_W    = 2;
  localparam int SLOTS   = 3;   // most tokens one character can cause
  localparam int SLOT_W  = 2;
  localparam int TQ_DEPTH = 2;  // step records held between lexer and serializer
  localparam int TQ_AW    = 1;
  localparam int TQ_CW    = 2;

  localparam logic [NUM_W-1:0] NUM_MAX = '1;

  typedef enum logic [2:0] {
    TK_NUM   = 3'd0,
    TK_SYM   = 3'd1,
    TK_IDENT = 3'd2,
    TK_KW    = 3'd3,
    TK_EOF   = 3'd4,
    TK_ERR   = 3'd5
  } tok_kind_t;

  // Punctuator codes
  localparam logic [PUNCT_W-1:0] PC_PLUS   = 5'd0;
  localparam logic [PUNCT_W-1:0] PC_MINUS  = 5'd1;
  localparam logic [PUNCT_W-1:0] PC_AMP    = 5'd2;
  localparam logic [PUNCT_W-1:0] PC_STAR   = 5'd3;
  localparam logic [PUNCT_W-1:0] PC_SLASH  = 5'd4;
  localparam logic [PUNCT_W-1:0] PC_LPAREN = 5'd5;
  localparam logic [PUNCT_W-1:0] PC_RPAREN = 5'd6;
  localparam logic [PUNCT_W-1:0] PC_LT     = 5'd7;
  localparam logic [PUNCT_W-1:0] PC_GT     = 5'd8;
  localparam logic [PUNCT_W-1:0] PC_SEMI   = 5'd9;
  localparam logic [PUNCT_W-1:0] PC_ASSIGN = 5'd10;
  localparam logic [PUNCT_W-1:0] PC_LBRACE = 5'd11;
  localparam logic [PUNCT_W-1:0] PC_RBRACE = 5'd12;
  localparam logic [PUNCT_W-1:0] PC_COMMA  = 5'd13;
  localparam logic [PUNCT_W-1:0] PC_LE     = 5'd14;  // then >=, !=, == in held order

  // Keyword codes
  localparam logic [KW_W-1:0] KWC_RETURN = 2'd0;
  localparam logic [KW_W-1:0] KWC_WHILE  = 2'd1;
  localparam logic [KW_W-1:0] KWC_FOR    = 2'd2;
  localparam logic [KW_W-1:0] KWC_INT    = 2'd3;

  // Keyword spellings packed first byte lowest
  localparam logic [TEXT_W-1:0] KWT_RETURN = 64'h0000_6E72_7574_6572;
  localparam logic [TEXT_W-1:0] KWT_WHILE  = 64'h0000_0065_6C69_6877;
  localparam logic [TEXT_W-1:0] KWT_FOR    = 64'h0000_0000_0072_6F66;
  localparam logic [TEXT_W-1:0] KWT_INT    = 64'h0000_0000_0074_6E69;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // One lexing step: up to three tokens, at most one number and one identifier
  typedef struct packed {
    logic [SLOT_W-1:0]               cnt;
    tok_kind_t [SLOTS-1:0]           kind;
    logic [SLOTS-1:0][PUNCT_W-1:0]   punct;
    logic [KW_W-1:0]                 kw;
    logic [NUM_W-1:0]                num;
    logic [TEXT_W-1:0]               text;
    logic [LEN_W-1:0]                len;
  } step_rec_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // {hit, code} for the single-character punctuators that need no lookahead
  function automatic logic [PUNCT_W:0] single_punct(input logic [7:0] c);
    logic [PUNCT_W:0] r;
    r = '0;
    unique case (c)
      CH_PLUS:   r = {1'b1, PC_PLUS};
      CH_MINUS:  r = {1'b1, PC_MINUS};
      CH_AMP:    r = {1'b1, PC_AMP};
      CH_STAR:   r = {1'b1, PC_STAR};
      CH_SLASH:  r = {1'b1, PC_SLASH};
      CH_LPAREN: r = {1'b1, PC_LPAREN};
      CH_RPAREN: r = {1'b1, PC_RPAREN};
      CH_SEMI:   r = {1'b1, PC_SEMI};
      CH_LBRACE: r = {1'b1, PC_LBRACE};
      CH_RBRACE: r = {1'b1, PC_RBRACE};
      CH_COMMA:  r = {1'b1, PC_COMMA};
      default:   r = '0;
    endcase
    return r;
  endfunction

  // {hit, code} of a finished identifier against the keyword list
  function automatic logic [KW_W:0] kw_lookup(input logic [TEXT_W-1:0] txt,
                                              input logic [LEN_W-1:0]  len);
    logic [KW_W:0] r;
    r = '0;
    priority if (len == 8'd6 && txt == KWT_RETURN) r = {1'b1, KWC_RETURN};
    else if (len == 8'd5 && txt == KWT_WHILE)      r = {1'b1, KWC_WHILE};
    else if (len == 8'd3 && txt == KWT_FOR)        r = {1'b1, KWC_FOR};
    else if (len == 8'd3 && txt == KWT_INT)        r = {1'b1, KWC_INT};
    else                                           r = '0;
    return r;
  endfunction

endpackage

// ----- rtl/core/lcx_scan.sv -----
// Input register and lexer state machine: turns one character into at most one step record.
module lcx_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_ch,
  input  logic                in_last,
  input  logic                q_room,
  output logic                rec_push,
  output lcx_pkg::step_rec_t  rec
);
  import lcx_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_NUM   = 3'd1,
    MODE_IDENT = 3'd2,
    MODE_HELD  = 3'd3,
    MODE_ERROR = 3'd4
  } lex_mode_t;

  typedef enum logic [1:0] {
    OP_LT   = 2'd0,
    OP_GT   = 2'd1,
    OP_BANG = 2'd2,
    OP_EQ   = 2'd3
  } held_op_t;

  logic                 iv_r;
  logic [7:0]           ich_r;
  logic                 ilast_r;

  lex_mode_t            mode_r, mode_nxt;
  held_op_t             held_r, held_nxt;
  logic [NUM_W-1:0]     acc_r, acc_nxt;
  logic [TEXT_W-1:0]    buf_r, buf_nxt;
  logic [LEN_W-1:0]     cnt_r, cnt_nxt;

  logic                 step_go;
  logic                 text_end;
  logic [NUM_W+3:0]     acc_x10;
  logic [3:0]           dig;
  logic [TEXT_W-1:0]    buf_app;
  logic [PUNCT_W:0]     sp;
  logic [KW_W:0]        kwl;
  step_rec_t            rec_v;

  assign step_go  = iv_r && q_room;
  assign in_ready = !iv_r || q_room;
  assign text_end = ilast_r || (ich_r == CH_NUL);
  assign dig      = 4'(ich_r - CH_ZERO);
  assign acc_x10  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {{NUM_W{1'b0}}, dig};
  assign sp       = single_punct(ich_r);

  // Append one byte at the current length while it is among the kept bytes
  always_comb begin
    buf_app = buf_r;
    for (int b = 0; b < IDENT_CHARS_KEPT; b++) begin
      if (cnt_r == LEN_W'(b)) buf_app[8*b +: 8] = ich_r;
    end
  end

  always_comb begin
    logic       do_start;
    logic [1:0] n;
    mode_nxt = mode_r;
    held_nxt = held_r;
    acc_nxt  = acc_r;
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    do_start = 1'b0;
    n        = '0;
    rec_v       = '0;
    rec_v.num   = acc_r;
    rec_v.text  = buf_r;
    rec_v.len   = cnt_r;

    if (mode_r == MODE_ERROR) begin
      // drop everything until end of text
      if (text_end) mode_nxt = MODE_IDLE;
    end else begin
      if (ich_r != CH_NUL) begin
        unique case (mode_r)
          MODE_NUM: begin
            if (is_digit(ich_r)) begin
              acc_nxt = (acc_x10 > {4'b0000, NUM_MAX}) ? NUM_MAX : acc_x10[NUM_W-1:0];
            end else begin
              rec_v.kind[n] = TK_NUM;
              n = n + 2'd1;
              mode_nxt = MODE_IDLE;
              do_start = 1'b1;
            end
          end
          MODE_IDENT: begin
            if (is_alpha(ich_r) || is_digit(ich_r) || ich_r == CH_USCORE) begin
              buf_nxt = buf_app;
              cnt_nxt = (cnt_r == '1) ? cnt_r : cnt_r + 8'd1;
            end else begin
              rec_v.kind[n] = TK_IDENT;
              n = n + 2'd1;
              mode_nxt = MODE_IDLE;
              do_start = 1'b1;
            end
          end
          MODE_HELD: begin
            if (ich_r == CH_EQ) begin
              rec_v.kind[n]  = TK_SYM;
              rec_v.punct[n] = PC_LE + {3'b000, held_r};
              n = n + 2'd1;
              mode_nxt = MODE_IDLE;
            end else if (held_r == OP_BANG) begin
              // lone bang: error, and this character is dropped
              rec_v.kind[n] = TK_ERR;
              n = n + 2'd1;
              mode_nxt = MODE_ERROR;
            end else begin
              rec_v.kind[n]  = TK_SYM;
              rec_v.punct[n] = (held_r == OP_LT) ? PC_LT :
                               (held_r == OP_GT) ? PC_GT : PC_ASSIGN;
              n = n + 2'd1;
              mode_nxt = MODE_IDLE;
              do_start = 1'b1;
            end
          end
          default: begin
            mode_nxt = MODE_IDLE;
            do_start = 1'b1;
          end
        endcase

        if (do_start) begin
          priority if (is_space(ich_r)) begin
            mode_nxt = MODE_IDLE;
          end else if (is_digit(ich_r)) begin
            acc_nxt  = {{(NUM_W-4){1'b0}}, dig};
            mode_nxt = MODE_NUM;
          end else if (is_alpha(ich_r) || ich_r == CH_USCORE) begin
            buf_nxt  = {{(TEXT_W-8){1'b0}}, ich_r};
            cnt_nxt  = 8'd1;
            mode_nxt = MODE_IDENT;
          end else if (ich_r == CH_LT || ich_r == CH_GT || ich_r == CH_BANG ||
                       ich_r == CH_EQ) begin
            held_nxt = (ich_r == CH_LT) ? OP_LT :
                       (ich_r == CH_GT) ? OP_GT :
                       (ich_r == CH_BANG) ? OP_BANG : OP_EQ;
            mode_nxt = MODE_HELD;
          end else if (sp[PUNCT_W]) begin
            rec_v.kind[n]  = TK_SYM;
            rec_v.punct[n] = sp[PUNCT_W-1:0];
            n = n + 2'd1;
            mode_nxt = MODE_IDLE;
          end else begin
            rec_v.kind[n] = TK_ERR;
            n = n + 2'd1;
            mode_nxt = MODE_ERROR;
          end
        end
      end

      // End of text: flush the pending token, then end of file unless the step ended in error
      if (text_end) begin
        unique case (mode_nxt)
          MODE_NUM: begin
            rec_v.kind[n] = TK_NUM;
            rec_v.num     = acc_nxt;
            n = n + 2'd1;
          end
          MODE_IDENT: begin
            rec_v.kind[n] = TK_IDENT;
            rec_v.text    = buf_nxt;
            rec_v.len     = cnt_nxt;
            n = n + 2'd1;
          end
          MODE_HELD: begin
            if (held_nxt == OP_BANG) begin
              rec_v.kind[n] = TK_ERR;
              mode_nxt = MODE_ERROR;
            end else begin
              rec_v.kind[n]  = TK_SYM;
              rec_v.punct[n] = (held_nxt == OP_LT) ? PC_LT :
                               (held_nxt == OP_GT) ? PC_GT : PC_ASSIGN;
            end
            n = n + 2'd1;
          end
          default: ;
        endcase
        if (mode_nxt != MODE_ERROR) begin
          rec_v.kind[n] = TK_EOF;
          n = n + 2'd1;
        end
        mode_nxt = MODE_IDLE;
      end
    end

    // Promote the identifier of this step to a keyword where it matches
    kwl = kw_lookup(rec_v.text, rec_v.len);
    rec_v.kw = kwl[KW_W-1:0];
    for (int s = 0; s < SLOTS; s++) begin
      if (rec_v.kind[s] == TK_IDENT && kwl[KW_W]) rec_v.kind[s] = TK_KW;
    end
    rec_v.cnt = n;
  end

  assign rec_push = step_go && (rec_v.cnt != '0);
  assign rec      = rec_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r   <= 1'b0;
      mode_r <= MODE_IDLE;
      held_r <= OP_LT;
      acc_r  <= '0;
      buf_r  <= '0;
      cnt_r  <= '0;
    end else begin
      if (in_ready) iv_r <= in_valid;
      if (step_go) begin
        mode_r <= mode_nxt;
        held_r <= held_nxt;
        acc_r  <= acc_nxt;
        buf_r  <= buf_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ich_r   <= in_ch;
      ilast_r <= in_last;
    end
  end

endmodule

// ----- rtl/core/lcx_tokq.sv -----
// Step record queue and serializer into the registered token output.
module lcx_tokq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                rec_push,
  input  lcx_pkg::step_rec_t                  rec,
  output logic                                q_room,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lcx_pkg::tok_kind_t                  out_kind,
  output logic [lcx_pkg::PUNCT_W-1:0]         out_punct,
  output logic [lcx_pkg::KW_W-1:0]            out_kw,
  output logic [lcx_pkg::NUM_W-1:0]           out_num,
  output logic [lcx_pkg::TEXT_W-1:0]          out_text,
  output logic [lcx_pkg::LEN_W-1:0]           out_len,
  output logic                                out_run_end
);
  import lcx_pkg::*;

  step_rec_t           mem [TQ_DEPTH];
  logic [TQ_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [TQ_CW-1:0]    q_cnt_r, q_cnt_nxt;
  logic [SLOT_W-1:0]   idx_r;
  logic                ov_r;

  step_rec_t           head;
  tok_kind_t           hkind;
  logic                load;
  logic                last_tok;
  logic                pop;

  assign head     = mem[rd_ptr_r];
  assign hkind    = head.kind[idx_r];
  assign q_room   = (q_cnt_r != TQ_CW'(TQ_DEPTH));
  assign load     = (q_cnt_r != '0) && (!ov_r || out_ready);
  assign last_tok = (idx_r == head.cnt - 2'd1);
  assign pop      = load && last_tok;

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    unique case ({rec_push, pop})
      2'b10:   q_cnt_nxt = q_cnt_r + 2'd1;
      2'b01:   q_cnt_nxt = q_cnt_r - 2'd1;
      default: q_cnt_nxt = q_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_push) mem[wr_ptr_r] <= rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
      idx_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (rec_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
        idx_r    <= '0;
      end else if (load) begin
        idx_r <= idx_r + 2'd1;
      end
      if (load)           ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // Payload fields are zero except on the kinds that carry them
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind    <= hkind;
      out_punct   <= (hkind == TK_SYM) ? head.punct[idx_r] : '0;
      out_kw      <= (hkind == TK_KW) ? head.kw : '0;
      out_num     <= (hkind == TK_NUM) ? head.num : '0;
      out_text    <= (hkind == TK_IDENT || hkind == TK_KW) ? head.text : '0;
      out_len     <= (hkind == TK_IDENT || hkind == TK_KW) ? head.len : '0;
      out_run_end <= last_tok;
    end
  end

  assign out_valid = ov_r;

endmodule

// ----- rtl/core/c_subset_lexer.sv -----
// Top level of the C subset lexer: stream ports, lexer stage and token serializer.
// A character passes the input register, the step record queue, then the token output register.
// Throughput: one character per cycle while each character causes at most one token and
// out_tready stays high; a character that causes k tokens (k up to 3) holds the output register
// until all k are taken, and input stalls once two step records wait in the queue.
// Reset (rst_n low, synchronous): lexer idle, queue empty, no output word valid.
module c_subset_lexer (
  input  logic          clk,
  input  logic          rst_n,
  // Source characters
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] ch
  input  logic          in_tlast,   // last character of the text
  // Tokens
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [143:0]  out_tdata,  // [4:0] punct_code, [6:5] keyword_code,
                                    // [69:7] number_value, [133:70] ident_text,
                                    // [141:134] ident_length, [143:142] zero
  output logic [2:0]    out_tuser,  // [2:0] token_kind
  output logic          out_tlast   // run_end: last token caused by one character
);
  import lcx_pkg::*;

  logic                  q_room;
  logic                  rec_push;
  step_rec_t             rec;
  tok_kind_t             tok_kind;
  logic [PUNCT_W-1:0]    tok_punct;
  logic [KW_W-1:0]       tok_kw;
  logic [NUM_W-1:0]      tok_num;
  logic [TEXT_W-1:0]     tok_text;
  logic [LEN_W-1:0]      tok_len;

  // Register the character, advance the lexer and build a step record
  lcx_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_ch    (in_tdata),
    .in_last  (in_tlast),
    .q_room   (q_room),
    .rec_push (rec_push),
    .rec      (rec)
  );

  // Hold step records and hand out their tokens one word at a time
  lcx_tokq u_tokq (
    .clk         (clk),
    .rst_n       (rst_n),
    .rec_push    (rec_push),
    .rec         (rec),
    .q_room      (q_room),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (tok_kind),
    .out_punct   (tok_punct),
    .out_kw      (tok_kw),
    .out_num     (tok_num),
    .out_text    (tok_text),
    .out_len     (tok_len),
    .out_run_end (out_tlast)
  );

  // Pack the word, first field lowest, padded to whole bytes
  assign out_tdata = {2'b00, tok_len, tok_text, tok_num, tok_kw, tok_punct};
  assign out_tuser = tok_kind;

endmodule

// ----- tb/c_subset_lexer_tb.sv -----
// Self-checking testbench for the C subset lexer: character stream in, token stream out.
module c_subset_lexer_tb;
  import lcx_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_PRINTS = 40;

  // Lexer modes of the predictor
  typedef enum logic [2:0] {
    LX_IDLE = 3'd0,
    LX_NUM  = 3'd1,
    LX_WORD = 3'd2,
    LX_HELD = 3'd3,
    LX_ERR  = 3'd4
  } lx_mode_t;

  // Operator held for one character of lookahead; order matches the two-char codes
  localparam logic [1:0] HOLD_LT   = 2'd0;
  localparam logic [1:0] HOLD_GT   = 2'd1;
  localparam logic [1:0] HOLD_BANG = 2'd2;
  localparam logic [1:0] HOLD_EQ   = 2'd3;

  typedef struct {
    tok_kind_t          kind;
    logic [PUNCT_W-1:0] punct;
    logic [KW_W-1:0]    kw;
    logic [NUM_W-1:0]   num;
    logic [TEXT_W-1:0]  text;
    logic [LEN_W-1:0]   len;
    logic               run_end;
  } lex_token_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  // Predictor state
  lx_mode_t          lx_mode;
  logic [1:0]        held_op;
  logic [NUM_W-1:0]  num_acc;
  logic [TEXT_W-1:0] word_buf;
  logic [LEN_W-1:0]  word_len;

  lex_token_t step_tokens[$];     // tokens of the character being lexed
  lex_token_t pending_tokens[$];  // tokens the block still owes, oldest first
  logic [7:0] text_bytes[$];      // random source text under construction

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int chars_sent = 0;
  int tokens_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;

  c_subset_lexer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run once the cycle count passes the limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding",
               cycle_count, pending_tokens.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic dec_char(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic word_start(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           c == CH_USCORE;
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void clear_lexer();
    lx_mode  = LX_IDLE;
    held_op  = HOLD_LT;
    num_acc  = '0;
    word_buf = '0;
    word_len = '0;
  endfunction

  function automatic void push_token(input tok_kind_t k, input logic [PUNCT_W-1:0] p,
                                     input logic [KW_W-1:0] kw, input logic [NUM_W-1:0] n,
                                     input logic [TEXT_W-1:0] t, input logic [LEN_W-1:0] l);
    lex_token_t tok;
    tok.kind = k;
    tok.punct = p;
    tok.kw = kw;
    tok.num = n;
    tok.text = t;
    tok.len = l;
    tok.run_end = 1'b0;
    step_tokens.insert(step_tokens.size(), tok);
  endfunction

  function automatic void push_plain(input tok_kind_t k, input logic [PUNCT_W-1:0] p);
    push_token(k, p, '0, '0, '0, '0);
  endfunction

  // Keep the first bytes of the identifier; the length saturates
  function automatic void word_append(input logic [7:0] c);
    if (word_len < IDENT_CHARS_KEPT) word_buf[8*word_len +: 8] = c;
    if (word_len != 8'hFF) word_len = word_len + 8'd1;
  endfunction

  function automatic void push_word();
    if (word_len == 8'd6 && word_buf == KWT_RETURN)
      push_token(TK_KW, '0, KWC_RETURN, '0, word_buf, word_len);
    else if (word_len == 8'd5 && word_buf == KWT_WHILE)
      push_token(TK_KW, '0, KWC_WHILE, '0, word_buf, word_len);
    else if (word_len == 8'd3 && word_buf == KWT_FOR)
      push_token(TK_KW, '0, KWC_FOR, '0, word_buf, word_len);
    else if (word_len == 8'd3 && word_buf == KWT_INT)
      push_token(TK_KW, '0, KWC_INT, '0, word_buf, word_len);
    else
      push_token(TK_IDENT, '0, '0, '0, word_buf, word_len);
  endfunction

  // Emit the held operator on its own; a lone bang is an error
  function automatic logic flush_held();
    if (held_op == HOLD_BANG) begin
      push_plain(TK_ERR, '0);
      lx_mode = LX_ERR;
      return 1'b0;
    end
    case (held_op)
      HOLD_LT: push_plain(TK_SYM, PC_LT);
      HOLD_GT: push_plain(TK_SYM, PC_GT);
      default: push_plain(TK_SYM, PC_ASSIGN);
    endcase
    lx_mode = LX_IDLE;
    return 1'b1;
  endfunction

  function automatic void start_char(input logic [7:0] c);
    if (blank_char(c)) return;
    if (dec_char(c)) begin
      num_acc = NUM_W'(c - CH_ZERO);
      lx_mode = LX_NUM;
      return;
    end
    if (word_start(c)) begin
      word_buf = '0;
      word_len = '0;
      word_append(c);
      lx_mode = LX_WORD;
      return;
    end
    case (c)
      CH_LT: begin held_op = HOLD_LT; lx_mode = LX_HELD; end
      CH_GT: begin held_op = HOLD_GT; lx_mode = LX_HELD; end
      CH_BANG: begin held_op = HOLD_BANG; lx_mode = LX_HELD; end
      CH_EQ: begin held_op = HOLD_EQ; lx_mode = LX_HELD; end
      CH_PLUS:   push_plain(TK_SYM, PC_PLUS);
      CH_MINUS:  push_plain(TK_SYM, PC_MINUS);
      CH_AMP:    push_plain(TK_SYM, PC_AMP);
      CH_STAR:   push_plain(TK_SYM, PC_STAR);
      CH_SLASH:  push_plain(TK_SYM, PC_SLASH);
      CH_LPAREN: push_plain(TK_SYM, PC_LPAREN);
      CH_RPAREN: push_plain(TK_SYM, PC_RPAREN);
      CH_SEMI:   push_plain(TK_SYM, PC_SEMI);
      CH_LBRACE: push_plain(TK_SYM, PC_LBRACE);
      CH_RBRACE: push_plain(TK_SYM, PC_RBRACE);
      CH_COMMA:  push_plain(TK_SYM, PC_COMMA);
      default: begin
        push_plain(TK_ERR, '0);
        lx_mode = LX_ERR;
      end
    endcase
  endfunction

  // Extend the pending token, or close it and lex the character afresh
  function automatic void feed_char(input logic [7:0] c);
    logic [63:0] digit;
    logic [63:0] acc_wide;
    logic [63:0] ceiling;
    ceiling = {1'b0, NUM_MAX};
    case (lx_mode)
      LX_NUM: begin
        if (dec_char(c)) begin
          digit = 64'(c - CH_ZERO);
          acc_wide = {1'b0, num_acc};
          if (acc_wide > (ceiling - digit) / 64'd10) num_acc = NUM_MAX;
          else num_acc = NUM_W'(acc_wide * 64'd10 + digit);
          return;
        end
        push_token(TK_NUM, '0, '0, num_acc, '0, '0);
      end
      LX_WORD: begin
        if (word_start(c) || dec_char(c)) begin
          word_append(c);
          return;
        end
        push_word();
      end
      LX_HELD: begin
        if (c == CH_EQ) begin
          push_plain(TK_SYM, PC_LE + PUNCT_W'(held_op));
          lx_mode = LX_IDLE;
          return;
        end
        // lone bang: the error swallows this character
        if (!flush_held()) return;
      end
      default: ;
    endcase
    lx_mode = LX_IDLE;
    start_char(c);
  endfunction

  // Work out every token one accepted character causes and queue them
  function automatic void predict_tokens(input logic [7:0] c, input logic last_flag);
    logic text_end;
    text_end = last_flag || c == CH_NUL;
    step_tokens.delete();
    if (lx_mode == LX_ERR) begin
      // drop characters until the text ends
      if (text_end) lx_mode = LX_IDLE;
      return;
    end
    if (c != CH_NUL) feed_char(c);
    if (text_end) begin
      case (lx_mode)
        LX_NUM:  push_token(TK_NUM, '0, '0, num_acc, '0, '0);
        LX_WORD: push_word();
        LX_HELD: void'(flush_held());
        default: ;
      endcase
      if (lx_mode != LX_ERR) push_plain(TK_EOF, '0);
      lx_mode = LX_IDLE;
    end
    for (int i = 0; i < step_tokens.size(); i++) begin
      if (i == step_tokens.size() - 1) step_tokens[i].run_end = 1'b1;
      pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Token checker and receiver stalls
  // ---------------------------------------------------------------------------

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("token %0d: %s mismatch, got %0h, want %0h", tokens_checked, what, got, want);
  endtask

  always @(posedge clk) begin
    lex_token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tokens.size() == 0) begin
        report("unexpected token kind", 64'(out_tuser), '0);
      end else begin
        want = pending_tokens.pop_front();
        if (out_tuser != want.kind) report("token_kind", 64'(out_tuser), 64'(want.kind));
        if (out_tdata[4:0] != want.punct)
          report("punct_code", 64'(out_tdata[4:0]), 64'(want.punct));
        if (out_tdata[6:5] != want.kw)
          report("keyword_code", 64'(out_tdata[6:5]), 64'(want.kw));
        if (out_tdata[69:7] != want.num)
          report("number_value", 64'(out_tdata[69:7]), 64'(want.num));
        if (out_tdata[133:70] != want.text)
          report("ident_text", out_tdata[133:70], want.text);
        if (out_tdata[141:134] != want.len)
          report("ident_length", 64'(out_tdata[141:134]), 64'(want.len));
        if (out_tdata[143:142] != 2'b00)
          report("pad bits", 64'(out_tdata[143:142]), '0);
        if (out_tlast != want.run_end)
          report("run_end", 64'(out_tlast), 64'(want.run_end));
      end
      tokens_checked++;
    end
    // hold off the result side at the phase's stall rate
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Character sender
  // ---------------------------------------------------------------------------

  // Drive one word and hold it until the block takes it
  task automatic send_char(input logic [7:0] c, input logic last_flag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= last_flag;
    do @(posedge clk); while (!in_tready);
    predict_tokens(c, last_flag);
    chars_sent++;
  endtask

  task automatic send_string(input string s, input logic last_on_final);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], last_on_final && i == s.len() - 1);
  endtask

  // Send the built text; close it with the last flag, a zero byte, or both
  task automatic send_text();
    int ending;
    ending = $urandom_range(9);
    for (int i = 0; i < text_bytes.size(); i++)
      send_char(text_bytes[i], ending < 7 && i == text_bytes.size() - 1);
    if (ending >= 7) send_char(CH_NUL, ending == 9);
  endtask

  function automatic void add_string(input string s);
    for (int i = 0; i < s.len(); i++) text_bytes.insert(text_bytes.size(), s[i]);
  endfunction

  function automatic logic [7:0] rand_word_char(input logic first);
    int pick;
    pick = $urandom_range(first ? 52 : 62);
    if (pick < 26) return CH_LO_A + 8'(pick);
    if (pick < 52) return CH_UP_A + 8'(pick - 26);
    if (pick == 52) return CH_USCORE;
    return CH_ZERO + 8'(pick - 53);
  endfunction

  // Append one lexeme of random kind and content
  function automatic void add_lexeme();
    string keywords[4] = '{"return", "while", "for", "int"};
    string operators[19] = '{"+", "-", "&", "*", "/", "(", ")", ";", "{", "}", ",",
                              "<", ">", "=", "<=", ">=", "!=", "==", "!"};
    logic [7:0] blanks[6] = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};
    string kw;
    int pick;
    int n;
    logic long_run;
    pick = $urandom_range(99);
    if (pick < 25) begin
      // long runs reach the saturation point
      long_run = $urandom_range(7) == 0;
      n = long_run ? $urandom_range(18, 21) : $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        text_bytes.insert(text_bytes.size(),
                          (long_run && $urandom_range(1)) ? CH_NINE
                                                          : CH_ZERO + 8'($urandom_range(9)));
    end else if (pick < 55) begin
      kw = keywords[$urandom_range(3)];
      case ($urandom_range(5))
        0: add_string(kw);
        1: begin
          // near misses of a keyword
          if ($urandom_range(1)) begin
            add_string(kw);
            text_bytes.insert(text_bytes.size(), rand_word_char(1'b0));
          end else begin
            add_string(kw.substr(0, kw.len() - 2));
          end
        end
        default: begin
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++)
            text_bytes.insert(text_bytes.size(), rand_word_char(i == 0));
        end
      endcase
    end else if (pick < 80) begin
      add_string(operators[$urandom_range(18)]);
    end else if (pick < 95) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) text_bytes.insert(text_bytes.size(), blanks[$urandom_range(5)]);
    end else begin
      text_bytes.insert(text_bytes.size(), 8'($urandom_range(1, 255)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero byte and last flag both end a text; a pending token flushes first
  task automatic test_end_of_text();
    send_char(CH_NUL, 1'b0);
    send_char(CH_NUL, 1'b1);
    send_char(CH_LO_A, 1'b1);
    send_char(CH_NINE, 1'b1);
  endtask

  // Lookahead pairs, held operators flushed by a punctuator and by end of text
  task automatic test_operators();
    send_string("<=>=!===<;=>", 1'b1);
  endtask

  // Lone bang, unknown high bytes, and recovery at end of text
  task automatic test_error_mode();
    send_char(CH_BANG, 1'b0);
    send_char(CH_LO_A, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'h80, 1'b1);
    send_char(CH_BANG, 1'b1);
  endtask

  // Identifier longer than the bytes it keeps
  task automatic test_long_identifier();
    text_bytes.delete();
    text_bytes.insert(text_bytes.size(), CH_USCORE);
    for (int i = 0; i < 19; i++) text_bytes.insert(text_bytes.size(), rand_word_char(1'b0));
    for (int i = 0; i < text_bytes.size(); i++) send_char(text_bytes[i], 1'b0);
    send_char(CH_SEMI, 1'b1);
  endtask

  task automatic test_random_text(input int idle_pct, input int stall_pct, input int n_chars);
    int stop_at;
    int n_lex;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      text_bytes.delete();
      n_lex = $urandom_range(2, 6);
      for (int i = 0; i < n_lex; i++) begin
        add_lexeme();
        if ($urandom_range(1)) text_bytes.insert(text_bytes.size(), CH_SPACE);
      end
      send_text();
    end
  endtask

  initial begin
    clear_lexer();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_end_of_text();
    test_operators();
    test_error_mode();

    // no idling, sender gaps, receiver stalls, then both
    test_random_text(0, 0, 40);
    test_random_text(50, 0, 40);
    test_random_text(0, 50, 40);
    test_long_identifier();
    test_random_text(20, 20, 40);

    in_tvalid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    // catch any token the block emits past the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
